// ----- sv/prt_pkg.sv -----
package prt_pkg;

	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic               cloud_end;
	} point_t;

	typedef struct packed {
		logic signed [31:0] moved_x;
		logic signed [31:0] moved_y;
		logic signed [31:0] moved_z;
		logic               moved_end;
	} moved_t;

	typedef logic signed [31:0] word_t;
	typedef word_t [8:0] coef_set_t;
	typedef word_t [2:0] offset_set_t;

	typedef struct packed {
		logic [15:0] roll;
		logic [15:0] pitch;
		logic [15:0] yaw;
	} angle_set_t;

	typedef enum logic [2:0] {
		REG_ROLL  = 3'd0,
		REG_PITCH = 3'd1,
		REG_YAW   = 3'd2,
		REG_OFF_X = 3'd3,
		REG_OFF_Y = 3'd4,
		REG_OFF_Z = 3'd5
	} reg_idx_t;

	localparam int CordicSteps = 24;
	localparam logic signed [33:0] CordicStart = 34'sd652032875;
	localparam logic signed [31:0] OneQ30 = 32'sh4000_0000;
	localparam logic signed [63:0] HalfQ30 = 64'sd536870912;

	function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
		logic signed [33:0] v;
		case (i)
			5'd0:    v = 34'sh20000000;
			5'd1:    v = 34'sh12E4051E;
			5'd2:    v = 34'sh09FB385B;
			5'd3:    v = 34'sh051111D4;
			5'd4:    v = 34'sh028B0D43;
			5'd5:    v = 34'sh0145D7E1;
			5'd6:    v = 34'sh00A2F61E;
			5'd7:    v = 34'sh00517C55;
			5'd8:    v = 34'sh0028BE53;
			5'd9:    v = 34'sh00145F2F;
			5'd10:   v = 34'sh000A2F98;
			5'd11:   v = 34'sh000517CC;
			5'd12:   v = 34'sh00028BE6;
			5'd13:   v = 34'sh000145F3;
			5'd14:   v = 34'sh0000A2FA;
			5'd15:   v = 34'sh0000517D;
			5'd16:   v = 34'sh000028BE;
			5'd17:   v = 34'sh0000145F;
			5'd18:   v = 34'sh00000A30;
			5'd19:   v = 34'sh00000518;
			5'd20:   v = 34'sh0000028C;
			5'd21:   v = 34'sh00000146;
			5'd22:   v = 34'sh000000A3;
			5'd23:   v = 34'sh00000051;
			default: v = 34'sh0;
		endcase
		return v;
	endfunction

endpackage

// ----- sv/prt_cordic.sv -----
module prt_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        angle,
	output logic               done,
	output logic signed [31:0] cos_val,
	output logic signed [31:0] sin_val
);

	logic signed [33:0] x_q, y_q, z_q;
	logic [4:0]         i_q;
	logic [1:0]         quad_q;
	logic               run_q, done_q;
	logic [15:0]        rounded, resid;
	logic [1:0]         quad;
	logic signed [33:0] xs, ys, at;

	// nearest quadrant, residual in -1/8..1/8 turn
	assign rounded = angle + 16'h2000;
	assign quad    = rounded[15:14];
	assign resid   = angle - {quad, 14'd0};

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign at = prt_pkg::atan_entry(i_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + 5'd1;
				if (i_q == 5'(prt_pkg::CordicSteps - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= prt_pkg::CordicStart;
			y_q    <= '0;
			z_q    <= {{2{resid[15]}}, resid, 16'd0};
			quad_q <= quad;
		end else if (run_q) begin
			if (!z_q[33]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	always_comb begin
		case (quad_q)
			2'd0: begin
				cos_val = x_q[31:0];
				sin_val = y_q[31:0];
			end
			2'd1: begin
				cos_val = -y_q[31:0];
				sin_val = x_q[31:0];
			end
			2'd2: begin
				cos_val = -x_q[31:0];
				sin_val = -y_q[31:0];
			end
			default: begin
				cos_val = y_q[31:0];
				sin_val = -x_q[31:0];
			end
		endcase
	end

	assign done = done_q;

endmodule

// ----- sv/prt_coef.sv -----
module prt_coef (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rebuild,
	input  prt_pkg::angle_set_t   angles,
	output logic                  busy,
	output prt_pkg::coef_set_t    coefs
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_LOAD = 5'b00010,
		ST_WAIT = 5'b00100,
		ST_MUL  = 5'b01000,
		ST_ACC  = 5'b10000
	} state_t;

	typedef enum logic [3:0] {
		OP_CR, OP_SR, OP_CP, OP_SP, OP_CY, OP_SY, OP_T1, OP_T2
	} opnd_t;

	typedef enum logic [2:0] {
		MD_T1, MD_T2, MD_U, MD_SET, MD_ADD, MD_SUB
	} mode_t;

	typedef struct packed {
		opnd_t      a;
		opnd_t      b;
		mode_t      mode;
		logic [3:0] dest;
	} step_t;

	localparam logic [3:0] LastStep = 4'd13;

	function automatic step_t prog(input logic [3:0] k);
		step_t s;
		case (k)
			4'd0:    s = '{OP_CY, OP_CP, MD_SET, 4'd0};
			4'd1:    s = '{OP_CY, OP_SP, MD_T1,  4'd0};
			4'd2:    s = '{OP_SY, OP_SP, MD_T2,  4'd0};
			4'd3:    s = '{OP_T1, OP_SR, MD_U,   4'd0};
			4'd4:    s = '{OP_SY, OP_CR, MD_SUB, 4'd1};
			4'd5:    s = '{OP_T1, OP_CR, MD_U,   4'd0};
			4'd6:    s = '{OP_SY, OP_SR, MD_ADD, 4'd2};
			4'd7:    s = '{OP_SY, OP_CP, MD_SET, 4'd3};
			4'd8:    s = '{OP_T2, OP_SR, MD_U,   4'd0};
			4'd9:    s = '{OP_CY, OP_CR, MD_ADD, 4'd4};
			4'd10:   s = '{OP_T2, OP_CR, MD_U,   4'd0};
			4'd11:   s = '{OP_CY, OP_SR, MD_SUB, 4'd5};
			4'd12:   s = '{OP_CP, OP_SR, MD_SET, 4'd7};
			default: s = '{OP_CP, OP_CR, MD_SET, 4'd8};
		endcase
		return s;
	endfunction

	function automatic logic signed [31:0] clamp30(input logic signed [34:0] v);
		logic signed [34:0] lim;
		lim = 35'(prt_pkg::OneQ30);
		if (v > lim)
			return prt_pkg::OneQ30;
		else if (v < -lim)
			return -prt_pkg::OneQ30;
		return v[31:0];
	endfunction

	state_t             state_q;
	logic [1:0]         idx_q;
	logic [3:0]         step_q;
	logic               pend_q;
	logic signed [31:0] cr_q, sr_q, cp_q, sp_q, cy_q, sy_q, t1_q, t2_q;
	logic signed [33:0] u_q;
	logic signed [63:0] prd_q, rnd;
	prt_pkg::coef_set_t m_q;

	logic               cs_done;
	logic signed [31:0] cs_cos, cs_sin;
	logic [15:0]        cs_angle;
	step_t              cur;
	logic signed [31:0] opa, opb;
	logic signed [33:0] r34;
	logic signed [34:0] acc;

	always_comb begin
		case (idx_q)
			2'd0:    cs_angle = angles.roll;
			2'd1:    cs_angle = angles.pitch;
			default: cs_angle = angles.yaw;
		endcase
	end

	prt_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ST_LOAD),
		.angle   (cs_angle),
		.done    (cs_done),
		.cos_val (cs_cos),
		.sin_val (cs_sin)
	);

	assign cur = prog(step_q);

	function automatic logic signed [31:0] pick(input opnd_t o, input logic signed [31:0] cr,
		input logic signed [31:0] sr, input logic signed [31:0] cp, input logic signed [31:0] sp,
		input logic signed [31:0] cy, input logic signed [31:0] sy, input logic signed [31:0] t1,
		input logic signed [31:0] t2);
		case (o)
			OP_CR:   return cr;
			OP_SR:   return sr;
			OP_CP:   return cp;
			OP_SP:   return sp;
			OP_CY:   return cy;
			OP_SY:   return sy;
			OP_T1:   return t1;
			default: return t2;
		endcase
	endfunction

	assign opa = pick(cur.a, cr_q, sr_q, cp_q, sp_q, cy_q, sy_q, t1_q, t2_q);
	assign opb = pick(cur.b, cr_q, sr_q, cp_q, sp_q, cy_q, sy_q, t1_q, t2_q);

	// round half up back to Q2.30
	assign rnd = prd_q + prt_pkg::HalfQ30;
	assign r34 = rnd[63:30];

	always_comb begin
		case (cur.mode)
			MD_ADD:  acc = 35'(u_q) + 35'(r34);
			MD_SUB:  acc = 35'(u_q) - 35'(r34);
			default: acc = 35'(r34);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			step_q  <= '0;
			pend_q  <= 1'b0;
			for (int i = 0; i < 9; i++)
				m_q[i] <= (i % 4 == 0) ? prt_pkg::OneQ30 : '0;
		end else begin
			// remember an angle write that lands mid-rebuild
			if (rebuild && busy && !(state_q == ST_ACC && step_q == LastStep))
				pend_q <= 1'b1;
			case (state_q)
				ST_IDLE: begin
					if (rebuild) begin
						idx_q   <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (cs_done) begin
						if (idx_q == 2'd2) begin
							step_q  <= '0;
							state_q <= ST_MUL;
						end else begin
							idx_q   <= idx_q + 2'd1;
							state_q <= ST_LOAD;
						end
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: begin
					case (cur.mode)
						MD_SET, MD_ADD, MD_SUB: m_q[cur.dest] <= clamp30(acc);
						default: ;
					endcase
					if (step_q == LastStep) begin
						m_q[6] <= clamp30(-35'(sp_q));
						pend_q <= 1'b0;
						if (pend_q || rebuild) begin
							idx_q   <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						step_q  <= step_q + 4'd1;
						state_q <= ST_MUL;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT && cs_done) begin
			case (idx_q)
				2'd0: begin
					cr_q <= cs_cos;
					sr_q <= cs_sin;
				end
				2'd1: begin
					cp_q <= cs_cos;
					sp_q <= cs_sin;
				end
				default: begin
					cy_q <= cs_cos;
					sy_q <= cs_sin;
				end
			endcase
		end
		if (state_q == ST_MUL)
			prd_q <= 64'(opa) * 64'(opb);
		if (state_q == ST_ACC) begin
			case (cur.mode)
				MD_T1:   t1_q <= r34[31:0];
				MD_T2:   t2_q <= r34[31:0];
				MD_U:    u_q  <= r34;
				default: ;
			endcase
		end
	end

	assign busy  = (state_q != ST_IDLE);
	assign coefs = m_q;

endmodule

// ----- sv/prt_pipe.sv -----
module prt_pipe (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 take,
	input  prt_pkg::point_t      point,
	input  prt_pkg::coef_set_t   coefs,
	input  prt_pkg::offset_set_t offsets,
	output logic                 room,
	output logic                 out_valid,
	input  logic                 out_stall,
	output prt_pkg::moved_t      moved
);

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1, en2, en3, en4;

	prt_pkg::point_t    pt_s1;
	logic signed [63:0] prod_s2 [9];
	logic               end_s2, end_s3;
	logic signed [65:0] sum_s3 [3];
	prt_pkg::moved_t    out_s4;

	logic signed [35:0] shr   [3];
	logic signed [36:0] biased[3];
	logic signed [31:0] sat   [3];
	logic signed [31:0] pin   [3];

	// a stage moves when it is empty or the one after it moves
	assign en4  = !v4_s4 || !out_stall;
	assign en3  = !v3_s3 || en4;
	assign en2  = !v2_s2 || en3;
	assign en1  = !v1_s1 || en2;
	assign room = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1) v1_s1 <= take;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
		end
	end

	assign pin[0] = pt_s1.point_x;
	assign pin[1] = pt_s1.point_y;
	assign pin[2] = pt_s1.point_z;

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			shr[r]    = sum_s3[r][65:30];
			biased[r] = 37'(shr[r]) + 37'(offsets[r]);
			if (biased[r] > 37'sh0_7FFF_FFFF)
				sat[r] = 32'sh7FFF_FFFF;
			else if (biased[r] < -37'sh0_8000_0000)
				sat[r] = 32'sh8000_0000;
			else
				sat[r] = biased[r][31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && take)
			pt_s1 <= point;
		if (en2 && v1_s1) begin
			for (int k = 0; k < 9; k++)
				prod_s2[k] <= 64'(coefs[k]) * 64'(pin[k % 3]);
			end_s2 <= pt_s1.cloud_end;
		end
		if (en3 && v2_s2) begin
			for (int r = 0; r < 3; r++)
				sum_s3[r] <= 66'(prod_s2[3*r]) + 66'(prod_s2[3*r+1])
					+ 66'(prod_s2[3*r+2]) + 66'(prt_pkg::HalfQ30);
			end_s3 <= end_s2;
		end
		if (en4 && v3_s3) begin
			out_s4.moved_x   <= sat[0];
			out_s4.moved_y   <= sat[1];
			out_s4.moved_z   <= sat[2];
			out_s4.moved_end <= end_s3;
		end
	end

	assign out_valid = v4_s4;
	assign moved     = out_s4;

endmodule

// ----- sv/point_rigid_transform.sv -----
// Rigid 3D transform of a point stream: each word x, y, z (Q16.16) leaves as
// R*p + t, saturated to signed 32 bits, with the cloud end flag carried along.
// The point path is a four-stage pipeline (capture, nine 32x32 products, row
// sums, shift plus offset plus saturate) that takes one word per clock while
// point_stall is low. Writing an angle register rebuilds the nine Q2.30
// coefficients: three 24-step CORDIC runs and fourteen multiply-round steps
// on one shared multiplier, during which point_stall stays high; an angle
// write that arrives during a rebuild starts another one when it finishes.
// Offset writes take effect at once. Registers at byte addresses 0..20 in
// steps of 4: roll, pitch, yaw (16-bit binary angles, 65536 per turn), offset
// x, y, z.
module point_rigid_transform (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             point_valid,
	output logic             point_stall,
	input  prt_pkg::point_t  point,
	output logic             moved_valid,
	input  logic             moved_stall,
	output prt_pkg::moved_t  moved
);

	logic [15:0]          roll_q, pitch_q, yaw_q;
	prt_pkg::offset_set_t off_q;
	prt_pkg::coef_set_t   coefs;
	prt_pkg::angle_set_t  angles;
	logic                 wr, angle_wr, busy, room, take;
	logic [2:0]           idx;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite;
	assign angle_wr = wr && (idx == prt_pkg::REG_ROLL || idx == prt_pkg::REG_PITCH
		|| idx == prt_pkg::REG_YAW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_q  <= '0;
			pitch_q <= '0;
			yaw_q   <= '0;
			off_q   <= '0;
		end else if (wr) begin
			case (idx)
				prt_pkg::REG_ROLL:  roll_q   <= pwdata[15:0];
				prt_pkg::REG_PITCH: pitch_q  <= pwdata[15:0];
				prt_pkg::REG_YAW:   yaw_q    <= pwdata[15:0];
				prt_pkg::REG_OFF_X: off_q[0] <= pwdata;
				prt_pkg::REG_OFF_Y: off_q[1] <= pwdata;
				prt_pkg::REG_OFF_Z: off_q[2] <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			prt_pkg::REG_ROLL:  prdata = {{16{roll_q[15]}}, roll_q};
			prt_pkg::REG_PITCH: prdata = {{16{pitch_q[15]}}, pitch_q};
			prt_pkg::REG_YAW:   prdata = {{16{yaw_q[15]}}, yaw_q};
			prt_pkg::REG_OFF_X: prdata = off_q[0];
			prt_pkg::REG_OFF_Y: prdata = off_q[1];
			prt_pkg::REG_OFF_Z: prdata = off_q[2];
			default:            prdata = '0;
		endcase
	end

	assign angles = '{roll: roll_q, pitch: pitch_q, yaw: yaw_q};

	prt_coef u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.rebuild (angle_wr),
		.angles  (angles),
		.busy    (busy),
		.coefs   (coefs)
	);

	assign point_stall = busy || !room;
	assign take        = point_valid && !point_stall;

	prt_pipe u_pipe (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.point     (point),
		.coefs     (coefs),
		.offsets   (off_q),
		.room      (room),
		.out_valid (moved_valid),
		.out_stall (moved_stall),
		.moved     (moved)
	);

endmodule

// ----- sv/prt_checker.sv -----
module prt_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            psel,
	input logic            penable,
	input logic            pwrite,
	input logic [4:0]      paddr,
	input logic            pready,
	input logic            point_stall,
	input logic            moved_valid,
	input logic            moved_stall,
	input prt_pkg::moved_t moved
);

	logic angle_wr;
	assign angle_wr = psel && penable && pwrite && pready
		&& (paddr[4:2] == prt_pkg::REG_ROLL || paddr[4:2] == prt_pkg::REG_PITCH
		|| paddr[4:2] == prt_pkg::REG_YAW);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		moved_valid && moved_stall |=> moved_valid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		moved_valid && moved_stall |=> $stable(moved))
		else $error("result word changed while stalled");

	// coefficient rebuild must block new points
	a_rebuild_stall: assert property (@(posedge clk) disable iff (!arst_n)
		angle_wr |=> point_stall)
		else $error("points accepted during coefficient rebuild");

	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !moved_valid)
		else $error("result word out of reset");

endmodule

bind point_rigid_transform prt_checker u_prt_checker (.*);
